[rtl/lrfp_pkg.sv]
// ----------------------------------------------------------------------------
// lrfp_pkg
// shared types and constants of the laser range frame parser
// ----------------------------------------------------------------------------
package lrfp_pkg;

    localparam int          BYTE_W      = 8;
    localparam int          DIST_W      = 29;
    localparam int          CNT_W       = 4;
    localparam int          QUEUE_DEPTH = 4;

    localparam logic [BYTE_W-1:0] START_BYTE  = 8'h80;
    localparam logic [BYTE_W-1:0] ERR_MARK    = 8'h45;
    localparam logic [BYTE_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CNT_W-1:0]  FRAME_STORE = 4'd11;

    // buffer positions of interest
    localparam logic [CNT_W-1:0]  POS_FIRST_DIGIT = 4'd3;

    // work item kinds passed from front to back
    typedef logic [1:0] kind_t;
    localparam kind_t K_FIRST = 2'd0;  // leading digit, also carries the error marker
    localparam kind_t K_DIGIT = 2'd1;  // following digit
    localparam kind_t K_END   = 2'd2;  // trailer seen, emit result

    typedef struct packed {
        kind_t              kind;
        logic [BYTE_W-1:0]  data;
    } work_t;

endpackage

[rtl/laser_range_frame_parser.sv]
// ----------------------------------------------------------------------------
// laser_range_frame_parser
// builds 12-byte rangefinder frames from serial bytes and reports distance
// ----------------------------------------------------------------------------
//  channel | dir | ports                          | content
//  --------+-----+--------------------------------+-----------------------------
//  s_      | in  | s_tvalid s_tready s_tdata[7:0] | received byte
//  m_      | out | m_tvalid m_tready m_tdata[31:0]| distance, padded to 32 bits
//          |     | m_tuser[0]                     | error frame flag
//
//  one byte transaction per cycle is taken while the work queue has room
//  a result appears after the trailer byte transaction passes through the
//    queue write and then the back end's result register
//  the back end retires one queue entry per cycle, so the queue only fills
//    while m_tready is held low; s_tready then drops until a result leaves
//  aresetn is synchronous, active low; no clearing pass, the block is ready
//    in the first cycle after reset
// ----------------------------------------------------------------------------
module laser_range_frame_parser #(
    parameter int QUEUE_DEPTH = lrfp_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    // byte input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // frame results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [28:0] distance, [31:29] zero
    output logic [0:0]  m_tuser    // [0] error_frame
);

    logic                          q_full;
    logic                          byte_accept;
    logic                          push;
    lrfp_pkg::work_t               push_item;
    logic                          pop_valid;
    lrfp_pkg::work_t               pop_item;
    logic                          pop;
    logic [lrfp_pkg::DIST_W-1:0]   distance;
    logic                          error_frame;

    // a byte is taken whenever the queue has room, whether or not it yields work
    assign s_tready    = !q_full;
    assign byte_accept = s_tvalid && s_tready;

    // front: start detection, byte position tracking, digit and trailer tagging
    lrfp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (byte_accept),
        .byte_data  (s_tdata),
        .push       (push),
        .push_item  (push_item)
    );

    // decouples frame tracking from result delivery
    lrfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop_valid (pop_valid),
        .pop_item  (pop_item),
        .pop       (pop)
    );

    // back: decimal accumulation, error check and result register
    lrfp_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_valid   (pop_valid),
        .item         (pop_item),
        .item_pop     (pop),
        .out_valid    (m_tvalid),
        .out_distance (distance),
        .out_error    (error_frame),
        .out_ready    (m_tready)
    );

    assign m_tdata = {{(32 - lrfp_pkg::DIST_W){1'b0}}, distance};
    assign m_tuser = error_frame;

endmodule

[rtl/lrfp_front.sv]
// ----------------------------------------------------------------------------
// lrfp_front
// frame tracking: finds the start byte, counts bytes, tags digits and trailer
// ----------------------------------------------------------------------------
module lrfp_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          byte_valid,
    input  logic [lrfp_pkg::BYTE_W-1:0]   byte_data,
    output logic                          push,
    output lrfp_pkg::work_t               push_item
);

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_START = 2'd1;
    localparam logic [1:0] PH_DATA  = 2'd2;
    localparam logic [1:0] PH_END   = 2'd3;

    logic [1:0]                  phase_reg, phase_next;
    logic [lrfp_pkg::CNT_W-1:0]  cnt_reg, cnt_next;

    always_comb begin
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        push           = 1'b0;
        push_item.kind = lrfp_pkg::K_DIGIT;
        push_item.data = byte_data;
        if (byte_valid) begin
            unique case (phase_reg)
                PH_IDLE: begin
                    if (byte_data == lrfp_pkg::START_BYTE) begin
                        cnt_next   = 4'd1;
                        phase_next = PH_START;
                    end
                end
                PH_START: begin
                    cnt_next   = cnt_reg + 4'd1;
                    phase_next = PH_DATA;
                end
                PH_DATA: begin
                    cnt_next = cnt_reg + 4'd1;
                    if (cnt_next == lrfp_pkg::FRAME_STORE) begin
                        phase_next = PH_END;
                    end
                    // position 6 carries no digit
                    unique case (cnt_reg) inside
                        lrfp_pkg::POS_FIRST_DIGIT: begin
                            push           = 1'b1;
                            push_item.kind = lrfp_pkg::K_FIRST;
                        end
                        4'd4, 4'd5, [4'd7:4'd10]: begin
                            push = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
                PH_END: begin
                    push           = 1'b1;
                    push_item.kind = lrfp_pkg::K_END;
                    cnt_next       = '0;
                    phase_next     = PH_IDLE;
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

[rtl/lrfp_queue.sv]
// ----------------------------------------------------------------------------
// lrfp_queue
// small first-in first-out store of work items between front and back
// ----------------------------------------------------------------------------
module lrfp_queue #(
    parameter int DEPTH = lrfp_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  lrfp_pkg::work_t  push_item,
    output logic             full,
    output logic             pop_valid,
    output lrfp_pkg::work_t  pop_item,
    input  logic             pop
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    lrfp_pkg::work_t   mem [DEPTH];
    logic [AW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]     count_reg, count_next;
    logic              do_push, do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_item  = mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (!do_push && do_pop) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
        end
    end

endmodule

[rtl/lrfp_back.sv]
// ----------------------------------------------------------------------------
// lrfp_back
// digit accumulation (times ten plus digit), error check, result register
// ----------------------------------------------------------------------------
module lrfp_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          item_valid,
    input  lrfp_pkg::work_t               item,
    output logic                          item_pop,
    output logic                          out_valid,
    output logic [lrfp_pkg::DIST_W-1:0]   out_distance,
    output logic                          out_error,
    input  logic                          out_ready
);

    localparam int DW = lrfp_pkg::DIST_W;

    logic [DW-1:0]                acc_reg, acc_next;
    logic [DW-1:0]                last_reg, last_next;
    logic                         err_reg, err_next;
    logic                         valid_reg, valid_next;
    logic [DW-1:0]                dist_reg, dist_next;
    logic                         oerr_reg, oerr_next;
    logic [lrfp_pkg::BYTE_W-1:0]  digit;
    logic                         slot_free;

    assign digit     = item.data - lrfp_pkg::ASCII_ZERO;
    assign slot_free = !valid_reg || out_ready;
    assign item_pop  = item_valid && ((item.kind != lrfp_pkg::K_END) || slot_free);

    always_comb begin
        acc_next   = acc_reg;
        err_next   = err_reg;
        last_next  = last_reg;
        valid_next = valid_reg && !out_ready;
        dist_next  = dist_reg;
        oerr_next  = oerr_reg;
        if (item_pop) begin
            unique case (item.kind)
                lrfp_pkg::K_FIRST: begin
                    acc_next = DW'(digit);
                    err_next = (item.data == lrfp_pkg::ERR_MARK);
                end
                lrfp_pkg::K_DIGIT: begin
                    // acc * 10 + digit, wraps at the field width
                    acc_next = (acc_reg << 3) + (acc_reg << 1) + DW'(digit);
                end
                lrfp_pkg::K_END: begin
                    if (!err_reg) begin
                        last_next = acc_reg;
                    end
                    valid_next = 1'b1;
                    dist_next  = err_reg ? last_reg : acc_reg;
                    oerr_next  = err_reg;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            last_reg  <= '0;
            err_reg   <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            last_reg  <= last_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg  <= acc_next;
        dist_reg <= dist_next;
        oerr_reg <= oerr_next;
    end

    assign out_valid    = valid_reg;
    assign out_distance = dist_reg;
    assign out_error    = oerr_reg;

endmodule

[rtl/lrfp_checker.sv]
// ----------------------------------------------------------------------------
// lrfp_checker
// port-level checks of the laser range frame parser
// ----------------------------------------------------------------------------
module lrfp_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic [0:0]  m_tuser
);

    logic [28:0] seen_dist_reg;

    // last delivered distance
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_dist_reg <= '0;
        end else if (m_tvalid && m_tready) begin
            seen_dist_reg <= m_tdata[28:0];
        end
    end

    // no result is left over from before reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a held result stays offered
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // an error frame repeats the distance last delivered
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tuser[0] |-> m_tdata[28:0] == seen_dist_reg)
        else $error("error frame changed the distance");

    // padding bits above the distance stay clear
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[31:29] == 3'b000)
        else $error("nonzero padding in result");

    // a byte held off stays offered with the same value
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("input byte changed while stalled");

endmodule

bind laser_range_frame_parser lrfp_checker u_lrfp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
